### rtl/rlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_pkg
// Shared types and constants of the RGB LED linear fade engine.
// ----------------------------------------------------------------------------
package rlf_pkg;

    localparam int COLOR_W   = 8;
    localparam int RGB_W     = 24;
    localparam int NUM_CH    = 3;
    localparam int DUR_W     = 16;
    localparam int ID_W      = 3;
    localparam int OP_W      = 3;
    localparam int DIV_NUM_W = 25;
    localparam int DIV_CNT_W = 5;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_SET     = 3'd1;
    localparam logic [OP_W-1:0] OP_FADE    = 3'd2;
    localparam logic [OP_W-1:0] OP_READ    = 3'd3;
    localparam logic [OP_W-1:0] OP_ALL_OFF = 3'd4;

    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_SET,
        KIND_FADE,
        KIND_READ,
        KIND_ALL_OFF,
        KIND_REJECT
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   led_id;
        logic [RGB_W-1:0]  color;
        logic [DUR_W-1:0]  dur;
    } cmd_t;

endpackage

### rtl/rlf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_cmd_if / rlf_rsp_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface rlf_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [2:0] led_id;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [15:0] fade_ms;

    modport source (output valid, output operation, output led_id, output red_in,
                    output green_in, output blue_in, output fade_ms, input ready);
    modport sink (input valid, input operation, input led_id, input red_in,
                  input green_in, input blue_in, input fade_ms, output ready);
endinterface

interface rlf_rsp_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [2:0] led_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last;

    modport source (output valid, output ok, output led_out, output red_out,
                    output green_out, output blue_out, output last, input ready);
    modport sink (input valid, input ok, input led_out, input red_out,
                  input green_out, input blue_out, input last, output ready);
endinterface

### rtl/rlf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_front
// Accepts command words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module rlf_front #(
    parameter int NUM_LEDS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    rlf_cmd_if.sink       cmd,
    output logic          q_valid,
    input  logic          q_ready,
    output rlf_pkg::cmd_t q_cmd
);

    rlf_pkg::cmd_t                  mem_reg [rlf_pkg::QDEPTH];
    logic [rlf_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [rlf_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [rlf_pkg::QCNT_W-1:0]     cnt_reg;
    rlf_pkg::cmd_t                  cls;
    logic                           good;
    logic                           push;
    logic                           pop;

    assign good = (cmd.led_id != 3'd0) && (int'(cmd.led_id) <= NUM_LEDS);

    always_comb
    begin
        cls.led_id = cmd.led_id;
        cls.color  = {cmd.red_in, cmd.green_in, cmd.blue_in};
        cls.dur    = cmd.fade_ms;
        case (cmd.operation)
            rlf_pkg::OP_TICK:    cls.kind = rlf_pkg::KIND_TICK;
            rlf_pkg::OP_SET:     cls.kind = good ? rlf_pkg::KIND_SET : rlf_pkg::KIND_REJECT;
            rlf_pkg::OP_FADE:    cls.kind = good ? rlf_pkg::KIND_FADE : rlf_pkg::KIND_REJECT;
            rlf_pkg::OP_READ:    cls.kind = good ? rlf_pkg::KIND_READ : rlf_pkg::KIND_REJECT;
            rlf_pkg::OP_ALL_OFF: cls.kind = rlf_pkg::KIND_ALL_OFF;
            default:             cls.kind = rlf_pkg::KIND_REJECT;
        endcase
    end

    assign cmd.ready = (cnt_reg != rlf_pkg::QCNT_W'(rlf_pkg::QDEPTH));
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (cnt_reg != '0);
    assign pop       = q_valid && q_ready;
    assign q_cmd     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/rlf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_div
// Three-lane restoring divider with a shared divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module rlf_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rlf_pkg::DIV_NUM_W-1:0] num [rlf_pkg::NUM_CH],
    input  logic [rlf_pkg::DUR_W-1:0]     den,
    output logic                          done,
    output logic [rlf_pkg::DIV_NUM_W-1:0] quot [rlf_pkg::NUM_CH]
);

    logic [rlf_pkg::DIV_NUM_W-1:0] sh_reg  [rlf_pkg::NUM_CH];
    logic [rlf_pkg::DUR_W-1:0]     rem_reg [rlf_pkg::NUM_CH];
    logic [rlf_pkg::DUR_W-1:0]     den_reg;
    logic [rlf_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [rlf_pkg::DUR_W:0]       trial   [rlf_pkg::NUM_CH];
    logic [rlf_pkg::NUM_CH-1:0]    ge;

    always_comb
    begin
        for (int k = 0; k < rlf_pkg::NUM_CH; k++)
        begin
            trial[k] = {rem_reg[k], sh_reg[k][rlf_pkg::DIV_NUM_W-1]};
            ge[k]    = (trial[k] >= {1'b0, den_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            for (int k = 0; k < rlf_pkg::NUM_CH; k++)
            begin
                sh_reg[k]  <= num[k];
                rem_reg[k] <= '0;
            end
        end
        else if (busy_reg)
        begin
            for (int k = 0; k < rlf_pkg::NUM_CH; k++)
            begin
                sh_reg[k]  <= {sh_reg[k][rlf_pkg::DIV_NUM_W-2:0], ge[k]};
                rem_reg[k] <= ge[k] ? rlf_pkg::DUR_W'(trial[k] - {1'b0, den_reg})
                                    : rlf_pkg::DUR_W'(trial[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= rlf_pkg::DIV_CNT_W'(rlf_pkg::DIV_NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule

### rtl/rlf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_back
// Executes queued commands: holds LED colors and fade records, runs ticks
// through the shared divider and drives the result register.
// ----------------------------------------------------------------------------
module rlf_back #(
    parameter int NUM_LEDS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  rlf_pkg::cmd_t q_cmd,
    rlf_rsp_if.source     rsp
);

    localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int SUM_W = IDX_W + 3;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LEDS - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_TICK  = 5'b00010,
        ST_START = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t                         state_reg;
    logic [rlf_pkg::RGB_W-1:0]      cur_reg    [NUM_LEDS];
    logic [rlf_pkg::RGB_W-1:0]      start_reg  [NUM_LEDS];
    logic [rlf_pkg::RGB_W-1:0]      target_reg [NUM_LEDS];
    logic [rlf_pkg::DUR_W-1:0]      el_reg     [NUM_LEDS];
    logic [rlf_pkg::DUR_W-1:0]      dur_reg    [NUM_LEDS];
    logic [NUM_LEDS-1:0]            active_reg;
    logic [IDX_W-1:0]               cnt_reg;
    logic                           tick_reg;
    logic                           res_ok_reg;
    logic [rlf_pkg::ID_W-1:0]       res_led_reg;
    logic [rlf_pkg::RGB_W-1:0]      res_color_reg;
    logic                           res_last_reg;
    logic [rlf_pkg::DIV_NUM_W-1:0]  num_reg    [rlf_pkg::NUM_CH];
    logic [rlf_pkg::NUM_CH-1:0]     neg_reg;
    logic                           out_valid_reg;
    logic                           out_ok_reg;
    logic [rlf_pkg::ID_W-1:0]       out_led_reg;
    logic [rlf_pkg::RGB_W-1:0]      out_color_reg;
    logic                           out_last_reg;

    logic [3:0]                     id_m1;
    logic [IDX_W-1:0]               cmd_idx;
    logic [IDX_W-1:0]               sel_idx;
    logic [SUM_W-1:0]               tick_led;
    logic [rlf_pkg::DUR_W-1:0]      el_inc;
    logic                           fade_done;
    logic [rlf_pkg::COLOR_W-1:0]    s_ch       [rlf_pkg::NUM_CH];
    logic [rlf_pkg::COLOR_W-1:0]    t_ch       [rlf_pkg::NUM_CH];
    logic [rlf_pkg::COLOR_W-1:0]    diff       [rlf_pkg::NUM_CH];
    logic [rlf_pkg::NUM_CH-1:0]     neg;
    logic [rlf_pkg::DIV_NUM_W-1:0]  prod       [rlf_pkg::NUM_CH];
    logic [rlf_pkg::DIV_NUM_W-1:0]  num        [rlf_pkg::NUM_CH];
    logic [rlf_pkg::DIV_NUM_W-1:0]  quot       [rlf_pkg::NUM_CH];
    logic [rlf_pkg::RGB_W-1:0]      blend;
    logic                           div_start;
    logic                           div_done;
    logic                           out_free;

    assign id_m1    = {1'b0, q_cmd.led_id} - 4'd1;
    assign cmd_idx  = id_m1[IDX_W-1:0];
    assign sel_idx  = (state_reg == ST_IDLE) ? cmd_idx : cnt_reg;
    assign tick_led = SUM_W'(cnt_reg) + SUM_W'(1);
    assign el_inc   = (el_reg[sel_idx] == '1) ? el_reg[sel_idx]
                                              : el_reg[sel_idx] + 1'b1;
    assign fade_done = (el_inc >= dur_reg[sel_idx]);
    assign q_ready   = (state_reg == ST_IDLE);
    assign div_start = (state_reg == ST_START);
    assign out_free  = !out_valid_reg || rsp.ready;

    // per-channel products, ceiling bias for falling channels
    always_comb
    begin
        for (int k = 0; k < rlf_pkg::NUM_CH; k++)
        begin
            s_ch[k] = start_reg[sel_idx][rlf_pkg::RGB_W-1-k*rlf_pkg::COLOR_W -: rlf_pkg::COLOR_W];
            t_ch[k] = target_reg[sel_idx][rlf_pkg::RGB_W-1-k*rlf_pkg::COLOR_W -: rlf_pkg::COLOR_W];
            neg[k]  = (t_ch[k] < s_ch[k]);
            diff[k] = neg[k] ? (s_ch[k] - t_ch[k]) : (t_ch[k] - s_ch[k]);
            prod[k] = rlf_pkg::DIV_NUM_W'(diff[k]) * rlf_pkg::DIV_NUM_W'(el_inc);
            num[k]  = neg[k] ? (prod[k] + rlf_pkg::DIV_NUM_W'(dur_reg[sel_idx])
                                - rlf_pkg::DIV_NUM_W'(1))
                             : prod[k];
            blend[rlf_pkg::RGB_W-1-k*rlf_pkg::COLOR_W -: rlf_pkg::COLOR_W] =
                neg_reg[k] ? (s_ch[k] - quot[k][rlf_pkg::COLOR_W-1:0])
                           : (s_ch[k] + quot[k][rlf_pkg::COLOR_W-1:0]);
        end
    end

    rlf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (dur_reg[cnt_reg]),
        .done  (div_done),
        .quot  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            cnt_reg       <= '0;
            tick_reg      <= 1'b0;
            res_ok_reg    <= 1'b0;
            res_led_reg   <= '0;
            res_color_reg <= '0;
            res_last_reg  <= 1'b0;
            neg_reg       <= '0;
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                cur_reg[i]    <= '0;
                start_reg[i]  <= '0;
                target_reg[i] <= '0;
                el_reg[i]     <= '0;
                dur_reg[i]    <= '0;
            end
            for (int k = 0; k < rlf_pkg::NUM_CH; k++)
            begin
                num_reg[k] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        tick_reg      <= (q_cmd.kind == rlf_pkg::KIND_TICK);
                        res_ok_reg    <= 1'b1;
                        res_led_reg   <= q_cmd.led_id;
                        res_color_reg <= cur_reg[cmd_idx];
                        res_last_reg  <= 1'b1;
                        state_reg     <= ST_EMIT;
                        case (q_cmd.kind)
                            rlf_pkg::KIND_TICK:
                            begin
                                cnt_reg   <= '0;
                                state_reg <= ST_TICK;
                            end
                            rlf_pkg::KIND_SET:
                            begin
                                cur_reg[cmd_idx] <= q_cmd.color;
                                res_color_reg    <= q_cmd.color;
                            end
                            rlf_pkg::KIND_FADE:
                            begin
                                active_reg[cmd_idx] <= 1'b1;
                                start_reg[cmd_idx]  <= cur_reg[cmd_idx];
                                target_reg[cmd_idx] <= q_cmd.color;
                                el_reg[cmd_idx]     <= '0;
                                dur_reg[cmd_idx]    <= q_cmd.dur;
                            end
                            rlf_pkg::KIND_READ:
                            begin
                            end
                            rlf_pkg::KIND_ALL_OFF:
                            begin
                                for (int i = 0; i < NUM_LEDS; i++)
                                begin
                                    cur_reg[i] <= '0;
                                end
                                res_led_reg   <= '0;
                                res_color_reg <= '0;
                            end
                            default:
                            begin
                                res_ok_reg    <= 1'b0;
                                res_color_reg <= '0;
                            end
                        endcase
                    end
                end
                ST_TICK:
                begin
                    res_ok_reg   <= 1'b1;
                    res_led_reg  <= tick_led[rlf_pkg::ID_W-1:0];
                    res_last_reg <= (cnt_reg == LAST_IDX);
                    if (!active_reg[cnt_reg])
                    begin
                        res_color_reg <= cur_reg[cnt_reg];
                        state_reg     <= ST_EMIT;
                    end
                    else if (fade_done)
                    begin
                        el_reg[cnt_reg]     <= el_inc;
                        cur_reg[cnt_reg]    <= target_reg[cnt_reg];
                        active_reg[cnt_reg] <= 1'b0;
                        res_color_reg       <= target_reg[cnt_reg];
                        state_reg           <= ST_EMIT;
                    end
                    else
                    begin
                        el_reg[cnt_reg] <= el_inc;
                        num_reg         <= num;
                        neg_reg         <= neg;
                        state_reg       <= ST_START;
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        cur_reg[cnt_reg] <= blend;
                        res_color_reg    <= blend;
                        state_reg        <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        if (tick_reg && (cnt_reg != LAST_IDX))
                        begin
                            cnt_reg   <= cnt_reg + 1'b1;
                            state_reg <= ST_TICK;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_led_reg   <= '0;
            out_color_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else if ((state_reg == ST_EMIT) && out_free)
        begin
            out_valid_reg <= 1'b1;
            out_ok_reg    <= res_ok_reg;
            out_led_reg   <= res_led_reg;
            out_color_reg <= res_color_reg;
            out_last_reg  <= res_last_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.ok        = out_ok_reg;
    assign rsp.led_out   = out_led_reg;
    assign rsp.red_out   = out_color_reg[23:16];
    assign rsp.green_out = out_color_reg[15:8];
    assign rsp.blue_out  = out_color_reg[7:0];
    assign rsp.last      = out_last_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside of wait state");

    a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && out_free) |=> out_valid_reg)
        else $error("result word not presented after emit");

    a_mid_word_is_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> tick_reg)
        else $error("non-final word outside a tick run");

endmodule

### rtl/rgb_led_linear_fade_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_linear_fade_engine
// Per-LED color store with linear fades advanced by a millisecond tick.
// ----------------------------------------------------------------------------
// Set color, start fade, read color, all off and rejected commands each give
// one result word, loaded into the output register from ST_EMIT. A tick gives
// NUM_LEDS result words, one per LED in order; an idle or finishing LED skips
// the divider, while a fading LED goes through the 25-step shared divider
// that all three color channels run through in parallel. A two-word command
// queue lets new words arrive while a tick is being worked off.
module rgb_led_linear_fade_engine #(
    parameter int NUM_LEDS = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    rlf_cmd_if.sink   cmd,
    rlf_rsp_if.source rsp
);

    logic          q_valid;
    logic          q_ready;
    rlf_pkg::cmd_t q_cmd;

    rlf_front #(
        .NUM_LEDS (NUM_LEDS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    rlf_back #(
        .NUM_LEDS (NUM_LEDS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .rsp     (rsp)
    );

endmodule
